@@ sv/lpc_pkg.sv @@
// lpc_pkg: sizes, register codes and the result type of the lru page cache lookup
// used by every module of the block; no dependencies
`timescale 1ns / 1ps

package lpc_pkg;

  localparam int SLOTS  = 16;
  localparam int IDX_W  = $clog2(SLOTS);
  localparam int AGE_W  = IDX_W;
  localparam int CNT_W  = $clog2(SLOTS + 1);
  localparam int PAGE_W = 32;
  localparam int SLOT_W = 4;
  localparam int CFG_W  = 5;
  localparam int DATA_W = 32;
  localparam int ADDR_W = 3;

  localparam logic [CFG_W-1:0] LIMIT_RESET = CFG_W'(16);

  // register index taken from paddr above the byte offset
  localparam logic [ADDR_W-3:0] REG_SLOTS_IN_USE = '0;

  typedef struct packed {
    logic              hit;
    logic [SLOT_W-1:0] slot;
    logic              evicted;
    logic [PAGE_W-1:0] evicted_page;
  } lpc_result_t;

endpackage

@@ sv/lpc_cfg.sv @@
// lpc_cfg: apb register holding slots_in_use and the clamped slot limit
// depends on lpc_pkg
`timescale 1ns / 1ps

module lpc_cfg (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [lpc_pkg::ADDR_W-1:0]   paddr,
  input  logic [lpc_pkg::DATA_W-1:0]   pwdata,
  output logic [lpc_pkg::DATA_W-1:0]   prdata,
  output logic                         pready,
  output logic [lpc_pkg::CNT_W-1:0]    limit_o
);

  localparam int CMP_W = (lpc_pkg::CNT_W > lpc_pkg::CFG_W) ? lpc_pkg::CNT_W : lpc_pkg::CFG_W;

  logic [lpc_pkg::CFG_W-1:0] limit_q;
  logic                      reg_sel;
  logic [CMP_W-1:0]          cfg_ext;
  logic [CMP_W-1:0]          lim;

  assign pready  = 1'b1;
  assign reg_sel = (paddr[lpc_pkg::ADDR_W-1:2] == lpc_pkg::REG_SLOTS_IN_USE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q <= lpc_pkg::LIMIT_RESET;
    end else if (psel && penable && pwrite && pready && reg_sel) begin
      limit_q <= pwdata[lpc_pkg::CFG_W-1:0];
    end
  end

  assign prdata = reg_sel ? lpc_pkg::DATA_W'(limit_q) : '0;

  // zero acts as one, anything above the slot count as the slot count
  always_comb begin
    cfg_ext = CMP_W'(limit_q);
    if (cfg_ext == '0) begin
      lim = CMP_W'(1);
    end else if (cfg_ext > CMP_W'(lpc_pkg::SLOTS)) begin
      lim = CMP_W'(lpc_pkg::SLOTS);
    end else begin
      lim = cfg_ext;
    end
  end

  assign limit_o = lim[lpc_pkg::CNT_W-1:0];

endmodule

@@ sv/lpc_cache.sv @@
// lpc_cache: slot tags, valid bits, recency ranks and fill count, with the
// parallel tag match, victim choice and rank update; depends on lpc_pkg
`timescale 1ns / 1ps

module lpc_cache (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        commit_i,
  input  logic [lpc_pkg::PAGE_W-1:0]  page_i,
  input  logic [lpc_pkg::CNT_W-1:0]   limit_i,
  output lpc_pkg::lpc_result_t        res_o
);

  localparam int SLOTS = lpc_pkg::SLOTS;
  localparam int IDX_W = lpc_pkg::IDX_W;
  localparam int AGE_W = lpc_pkg::AGE_W;
  localparam int CNT_W = lpc_pkg::CNT_W;

  logic [lpc_pkg::PAGE_W-1:0] tag_q [SLOTS];
  logic [SLOTS-1:0]           valid_q;
  logic [AGE_W-1:0]           age_q [SLOTS];
  logic [CNT_W-1:0]           filled_q;

  logic [SLOTS-1:0] match;
  logic [SLOTS-1:0] oldest;
  logic             hit;
  logic             fresh;
  logic [IDX_W-1:0] hit_idx;
  logic [IDX_W-1:0] old_idx;
  logic [IDX_W-1:0] sel_idx;
  logic [AGE_W-1:0] sel_age;
  logic [CNT_W-1:0] filled_m1;
  logic [AGE_W-1:0] oldest_age;
  logic [31:0]      sel_ext;

  assign filled_m1  = filled_q - CNT_W'(1);
  assign oldest_age = filled_m1[AGE_W-1:0];

  // ranks of filled slots form 0 .. filled-1, so the least recent holds filled-1
  always_comb begin
    for (int i = 0; i < SLOTS; i++) begin
      match[i]  = valid_q[i] && (tag_q[i] == page_i);
      oldest[i] = valid_q[i] && (age_q[i] == oldest_age);
    end
  end

  always_comb begin
    hit_idx = '0;
    old_idx = '0;
    for (int i = SLOTS - 1; i >= 0; i--) begin
      if (match[i]) begin
        hit_idx = IDX_W'(i);
      end
      if (oldest[i]) begin
        old_idx = IDX_W'(i);
      end
    end
  end

  assign hit   = |match;
  assign fresh = !hit && (filled_q < limit_i) && (filled_q < CNT_W'(SLOTS));

  always_comb begin
    if (hit) begin
      sel_idx = hit_idx;
    end else if (fresh) begin
      sel_idx = filled_q[IDX_W-1:0];
    end else begin
      sel_idx = old_idx;
    end
  end

  assign sel_age = age_q[sel_idx];
  assign sel_ext = 32'(sel_idx);

  assign res_o.hit          = hit;
  assign res_o.slot         = sel_ext[lpc_pkg::SLOT_W-1:0];
  assign res_o.evicted      = !hit && !fresh;
  assign res_o.evicted_page = (!hit && !fresh) ? tag_q[old_idx] : '0;

  always_ff @(posedge clk_i) begin
    if (commit_i && !hit) begin
      tag_q[sel_idx] <= page_i;
    end
  end

  // on a miss every other filled slot ages; on a hit only the younger ones
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q  <= '0;
      filled_q <= '0;
      for (int i = 0; i < SLOTS; i++) begin
        age_q[i] <= '0;
      end
    end else if (commit_i) begin
      for (int i = 0; i < SLOTS; i++) begin
        if (IDX_W'(i) == sel_idx) begin
          age_q[i]   <= '0;
          valid_q[i] <= 1'b1;
        end else if (valid_q[i] && (!hit || (age_q[i] < sel_age))) begin
          age_q[i] <= age_q[i] + AGE_W'(1);
        end
      end
      if (fresh) begin
        filled_q <= filled_q + CNT_W'(1);
      end
    end
  end

  a_filled_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    filled_q <= CNT_W'(SLOTS))
    else $error("fill count above slot count");

  a_single_match : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0(match))
    else $error("page held by more than one slot");

  a_valid_count : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $countones(valid_q) == int'(filled_q))
    else $error("valid bits disagree with fill count");

  a_evict_keeps_fill : assert property (@(posedge clk_i) disable iff (!rst_ni)
    commit_i && !hit && !fresh |=> $stable(filled_q))
    else $error("eviction changed the fill count");

  a_evict_has_victim : assert property (@(posedge clk_i) disable iff (!rst_ni)
    commit_i && !hit && !fresh |-> $onehot(oldest))
    else $error("no unique least recent slot on eviction");

endmodule

@@ sv/lru_page_cache_lookup_core.sv @@
// lru_page_cache_lookup_core: top level with request register, cache core and
// result register; depends on lpc_pkg, lpc_cfg and lpc_cache
//
//   channel   direction  handshake                 payload
//   request   in         in_valid_i / in_ready_o   page_number_i
//   result    out        out_valid_o / out_ready_i hit_o, slot_o, evicted_o, evicted_page_o
//   config    in         psel, penable, pwrite     paddr, pwdata, prdata
//
// one request per cycle while the result is not stalled; the tag match and
// rank update sit between the request register and the result register
// reset clears valid bits, ranks and fill count at once and sets slots_in_use to 16
// a stalled result holds a pending request in place, so no new request is taken
`timescale 1ns / 1ps

module lru_page_cache_lookup_core (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic [lpc_pkg::PAGE_W-1:0]  page_number_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic                        hit_o,
  output logic [lpc_pkg::SLOT_W-1:0]  slot_o,
  output logic                        evicted_o,
  output logic [lpc_pkg::PAGE_W-1:0]  evicted_page_o,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [lpc_pkg::ADDR_W-1:0]  paddr,
  input  logic [lpc_pkg::DATA_W-1:0]  pwdata,
  output logic [lpc_pkg::DATA_W-1:0]  prdata,
  output logic                        pready
);

  logic                       req_valid_q;
  logic [lpc_pkg::PAGE_W-1:0] req_page_q;
  logic                       out_valid_q;
  lpc_pkg::lpc_result_t       res_q;
  lpc_pkg::lpc_result_t       res_d;
  logic [lpc_pkg::CNT_W-1:0]  limit;
  logic                       advance;

  assign advance    = req_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !req_valid_q || advance;

  lpc_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .limit_o (limit)
  );

  lpc_cache u_cache (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .commit_i (advance),
    .page_i   (req_page_q),
    .limit_i  (limit),
    .res_o    (res_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_valid_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_valid_i && in_ready_o) begin
        req_valid_q <= 1'b1;
      end else if (advance) begin
        req_valid_q <= 1'b0;
      end
      if (advance) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      req_page_q <= page_number_i;
    end
    if (advance) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign hit_o          = res_q.hit;
  assign slot_o         = res_q.slot;
  assign evicted_o      = res_q.evicted;
  assign evicted_page_o = res_q.evicted_page;

endmodule

@@ verif/tb_top.sv @@
// tb_top: self-checking bench for lru_page_cache_lookup_core, a directed table then random
// page requests, mostly under random stalls, each result checked against an lru cache
// predictor or the typed table result; depends on lpc_pkg and lru_page_cache_lookup_core
`timescale 1ns / 1ps

module tb_top;

  localparam int ADDR_W = lpc_pkg::ADDR_W;
  localparam int PAGE_W = lpc_pkg::PAGE_W;
  localparam int DATA_W = lpc_pkg::DATA_W;
  localparam int SLOT_W = lpc_pkg::SLOT_W;
  localparam int CFG_W  = lpc_pkg::CFG_W;
  localparam int SLOTS  = lpc_pkg::SLOTS;
  localparam logic [ADDR_W-3:0] REG_SLOTS_IN_USE = lpc_pkg::REG_SLOTS_IN_USE;
  localparam logic [CFG_W-1:0]  LIMIT_RESET      = lpc_pkg::LIMIT_RESET;

  typedef enum logic {ROW_REQ, ROW_CFG} row_kind_e;

  typedef struct {
    row_kind_e            kind;
    logic [ADDR_W-1:0]    addr;
    logic [PAGE_W-1:0]    data;
    bit                   typed;
    lpc_pkg::lpc_result_t res;
  } stim_row_t;

  localparam logic [ADDR_W-1:0] ADDR_LIMIT    = {REG_SLOTS_IN_USE, 2'b00};
  localparam logic [ADDR_W-1:0] ADDR_UNMAPPED = ADDR_W'(4);
  localparam int N_DIR       = 26;
  localparam int N_SEG       = 11;
  localparam int SEG_ITEMS   = 40;
  localparam int POOL_N      = 20;
  localparam int CYCLE_LIMIT = 200000;

  logic              clk_i          = 1'b0;
  logic              rst_ni         = 1'b0;
  logic              in_valid_i     = 1'b0;
  logic              in_ready_o;
  logic [PAGE_W-1:0] page_number_i  = '0;
  logic              out_valid_o;
  logic              out_ready_i    = 1'b0;
  logic              hit_o;
  logic [SLOT_W-1:0] slot_o;
  logic              evicted_o;
  logic [PAGE_W-1:0] evicted_page_o;
  logic              psel           = 1'b0;
  logic              penable        = 1'b0;
  logic              pwrite         = 1'b0;
  logic [ADDR_W-1:0] paddr          = '0;
  logic [DATA_W-1:0] pwdata         = '0;
  logic [DATA_W-1:0] prdata;
  logic              pready;

  lru_page_cache_lookup_core dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .page_number_i  (page_number_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .hit_o          (hit_o),
    .slot_o         (slot_o),
    .evicted_o      (evicted_o),
    .evicted_page_o (evicted_page_o),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // predictor copy of the cache
  logic [PAGE_W-1:0] cache_tag   [SLOTS];
  bit                cache_valid [SLOTS];
  int unsigned       cache_rank  [SLOTS];
  int unsigned       cache_filled;
  logic [CFG_W-1:0]  cfg_limit;

  lpc_pkg::lpc_result_t lookup_exp_q [$];
  bit                   req_typed     = 1'b0;
  lpc_pkg::lpc_result_t req_typed_res = '0;
  int                   snd_idle      = 0;
  int                   rcv_idle      = 0;
  int                   err_count     = 0;
  int                   results_seen  = 0;
  int                   hits_seen     = 0;
  int                   evicts_seen   = 0;
  int                   reg_writes    = 0;
  int                   cycle_cnt     = 0;
  logic [PAGE_W-1:0]    page_pool [POOL_N];

  stim_row_t dir_rows [N_DIR] = '{
    '{ROW_REQ, ADDR_LIMIT,    32'h0000_0000, 1'b1, '{1'b0, 4'd0, 1'b0, 32'h0}},
    '{ROW_REQ, ADDR_LIMIT,    32'hFFFF_FFFF, 1'b1, '{1'b0, 4'd1, 1'b0, 32'h0}},
    '{ROW_REQ, ADDR_LIMIT,    32'h0000_0000, 1'b1, '{1'b1, 4'd0, 1'b0, 32'h0}},
    '{ROW_REQ, ADDR_LIMIT,    32'hFFFF_FFFF, 1'b1, '{1'b1, 4'd1, 1'b0, 32'h0}},
    '{ROW_REQ, ADDR_LIMIT,    32'h0000_0000, 1'b1, '{1'b1, 4'd0, 1'b0, 32'h0}},
    '{ROW_CFG, ADDR_LIMIT,    32'd2,         1'b0, '0},
    '{ROW_REQ, ADDR_LIMIT,    32'h8000_0000, 1'b1, '{1'b0, 4'd1, 1'b1, 32'hFFFF_FFFF}},
    '{ROW_CFG, ADDR_LIMIT,    32'd0,         1'b0, '0},
    '{ROW_REQ, ADDR_LIMIT,    32'h1234_5678, 1'b1, '{1'b0, 4'd0, 1'b1, 32'h0}},
    '{ROW_REQ, ADDR_LIMIT,    32'h8000_0000, 1'b1, '{1'b1, 4'd1, 1'b0, 32'h0}},
    '{ROW_CFG, ADDR_LIMIT,    32'd31,        1'b0, '0},
    '{ROW_REQ, ADDR_LIMIT,    32'h7FFF_FFFF, 1'b1, '{1'b0, 4'd2, 1'b0, 32'h0}},
    '{ROW_REQ, ADDR_LIMIT,    32'h0000_0001, 1'b1, '{1'b0, 4'd3, 1'b0, 32'h0}},
    '{ROW_CFG, ADDR_UNMAPPED, 32'd1,         1'b0, '0},
    '{ROW_REQ, ADDR_LIMIT,    32'h5555_5555, 1'b1, '{1'b0, 4'd4, 1'b0, 32'h0}},
    '{ROW_CFG, ADDR_LIMIT,    32'd17,        1'b0, '0},
    '{ROW_REQ, ADDR_LIMIT,    32'hAAAA_AAAA, 1'b0, '0},
    '{ROW_REQ, ADDR_LIMIT,    32'h0000_FFFF, 1'b0, '0},
    '{ROW_REQ, ADDR_LIMIT,    32'hFFFF_0000, 1'b0, '0},
    '{ROW_REQ, ADDR_LIMIT,    32'h1234_5678, 1'b0, '0},
    '{ROW_CFG, ADDR_LIMIT,    32'd1,         1'b0, '0},
    '{ROW_REQ, ADDR_LIMIT,    32'hDEAD_BEEF, 1'b0, '0},
    '{ROW_REQ, ADDR_LIMIT,    32'h0000_0001, 1'b0, '0},
    '{ROW_CFG, ADDR_LIMIT,    32'd16,        1'b0, '0},
    '{ROW_REQ, ADDR_LIMIT,    32'hCAFE_F00D, 1'b0, '0},
    '{ROW_REQ, ADDR_LIMIT,    32'hFFFF_FFFF, 1'b0, '0}
  };

  function automatic int unsigned limit_in_force();
    int unsigned lim;
    lim = 32'(cfg_limit);
    if (lim < 1) lim = 1;
    if (lim > SLOTS) lim = SLOTS;
    return lim;
  endfunction

  function automatic void make_recent(int unsigned s, int unsigned bound);
    for (int unsigned i = 0; i < SLOTS; i++) begin
      if (cache_valid[i] && i != s && cache_rank[i] < bound) cache_rank[i]++;
    end
    cache_rank[s] = 0;
  endfunction

  function automatic lpc_pkg::lpc_result_t predict_lookup(logic [PAGE_W-1:0] page);
    int unsigned          s;
    int unsigned          oldest;
    bit                   found;
    bit                   any;
    lpc_pkg::lpc_result_t r;
    s      = 0;
    found  = 1'b0;
    any    = 1'b0;
    oldest = 0;
    r      = '0;
    for (int unsigned i = 0; i < SLOTS; i++) begin
      if (!found && cache_valid[i] && cache_tag[i] == page) begin
        found = 1'b1;
        s     = i;
      end
    end
    if (found) begin
      r.hit = 1'b1;
      make_recent(s, cache_rank[s]);
    end else if (cache_filled < limit_in_force() && cache_filled < SLOTS) begin
      s              = cache_filled;
      cache_valid[s] = 1'b1;
      cache_tag[s]   = page;
      cache_filled++;
      make_recent(s, SLOTS);
    end else begin
      // least recent of all filled slots goes
      for (int unsigned i = 0; i < SLOTS; i++) begin
        if (cache_valid[i] && (!any || cache_rank[i] > oldest)) begin
          any    = 1'b1;
          oldest = cache_rank[i];
          s      = i;
        end
      end
      if (any) begin
        r.evicted      = 1'b1;
        r.evicted_page = cache_tag[s];
      end
      cache_valid[s] = 1'b1;
      cache_tag[s]   = page;
      make_recent(s, oldest);
    end
    r.slot = SLOT_W'(s);
    return r;
  endfunction

  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("%0t: timed out, %0d results outstanding", $time, lookup_exp_q.size());
      $display("tb_top: errors");
      $finish;
    end
  end

  always @(negedge clk_i) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= ($urandom_range(0, 99) >= rcv_idle);
    end
  end

  always @(posedge clk_i) begin
    lpc_pkg::lpc_result_t got;
    lpc_pkg::lpc_result_t want;
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        got = {hit_o, slot_o, evicted_o, evicted_page_o};
        if (lookup_exp_q.size() == 0) begin
          err_count++;
          $display("%0t: unexpected result hit=%0b slot=%0d evicted=%0b page=%08h",
                   $time, got.hit, got.slot, got.evicted, got.evicted_page);
        end else begin
          want = lookup_exp_q.pop_front();
          results_seen++;
          hits_seen   += int'(want.hit);
          evicts_seen += int'(want.evicted);
          if (got.hit !== want.hit || got.slot !== want.slot ||
              got.evicted !== want.evicted || got.evicted_page !== want.evicted_page) begin
            err_count++;
            $display("%0t: mismatch exp h=%0b s=%0d e=%0b p=%08h act h=%0b s=%0d e=%0b p=%08h",
                     $time, want.hit, want.slot, want.evicted, want.evicted_page,
                     got.hit, got.slot, got.evicted, got.evicted_page);
          end
        end
      end
      if (in_valid_i && in_ready_o) begin
        want = predict_lookup(page_number_i);
        if (req_typed) want = req_typed_res;
        lookup_exp_q.push_back(want);
      end
    end
  end

  task automatic send_lookup(input logic [PAGE_W-1:0] page, input bit typed,
                             input lpc_pkg::lpc_result_t res);
    @(negedge clk_i);
    while ($urandom_range(0, 99) < snd_idle) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i    <= 1'b1;
    page_number_i <= page;
    req_typed     <= typed;
    req_typed_res <= res;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  task automatic settle_results();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (lookup_exp_q.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [ADDR_W-1:0] addr, input logic [DATA_W-1:0] value);
    logic [DATA_W-1:0] word;
    word            = $urandom();
    word[CFG_W-1:0] = value[CFG_W-1:0];
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= word;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    if (addr[ADDR_W-1:2] == REG_SLOTS_IN_USE) cfg_limit = word[CFG_W-1:0];
    reg_writes++;
    // read back
    @(negedge clk_i);
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    if (addr[ADDR_W-1:2] == REG_SLOTS_IN_USE && prdata !== DATA_W'(cfg_limit)) begin
      err_count++;
      $display("%0t: readback mismatch exp %08h act %08h", $time, DATA_W'(cfg_limit), prdata);
    end
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  initial begin
    int                seg_limit [N_SEG];
    int                pool_n;
    logic [PAGE_W-1:0] page;
    for (int i = 0; i < SLOTS; i++) begin
      cache_tag[i]   = '0;
      cache_valid[i] = 1'b0;
      cache_rank[i]  = 0;
    end
    cache_filled = 0;
    cfg_limit    = LIMIT_RESET;
    for (int i = 0; i < POOL_N; i++) page_pool[i] = $urandom();
    page_pool[0] = '0;
    page_pool[1] = '1;
    snd_idle     = 20;
    rcv_idle     = 55;

    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    foreach (dir_rows[r]) begin
      if (dir_rows[r].kind == ROW_CFG) begin
        settle_results();
        write_reg(dir_rows[r].addr, dir_rows[r].data);
      end else begin
        send_lookup(dir_rows[r].data, dir_rows[r].typed, dir_rows[r].res);
      end
    end

    seg_limit    = '{16, 1, 4, 0, 31, 8, 2, 17, 12, 0, 16};
    seg_limit[9] = $urandom_range(0, 31);
    for (int seg = 0; seg < N_SEG; seg++) begin
      settle_results();
      write_reg(ADDR_LIMIT, seg_limit[seg]);
      if (seg < 4) begin
        snd_idle = 20;
        rcv_idle = 55;
      end else if (seg < 8) begin
        snd_idle = 55;
        rcv_idle = 20;
      end else begin
        snd_idle = 0;
        rcv_idle = 0;
      end
      // working set a little larger than the slots in force
      pool_n = limit_in_force() + 4;
      for (int k = 0; k < SEG_ITEMS; k++) begin
        if (seg == 5 && k == SEG_ITEMS / 2) settle_results();
        if ($urandom_range(0, 3) == 0) page = $urandom();
        else page = page_pool[$urandom_range(0, pool_n - 1)];
        send_lookup(page, 1'b0, '0);
      end
    end

    rcv_idle = 0;
    settle_results();
    repeat (8) @(posedge clk_i);

    $display("tb_top: %0d lookups checked, %0d hits, %0d evictions", results_seen, hits_seen,
             evicts_seen);
    $display("tb_top: %0d register writes over %0d limit settings, %0d errors", reg_writes,
             N_SEG, err_count);
    if (err_count == 0) begin
      $display("tb_top: clean");
    end else begin
      $display("tb_top: errors");
    end
    $finish;
  end

endmodule
